### rtl/core/mrf_pkg.sv
// Package for the Modbus RTU request framer.
// Holds codes, the command record passed from front to back, and the CRC step.
// No dependencies.
package mrf_pkg;

    localparam int MAX_FRAME_DEFAULT = 64;
    localparam int QUEUE_DEPTH       = 2;
    localparam int CMD_BYTES         = 7;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  MAX_SLAVE = 8'd247;
    localparam logic [15:0] COIL_ON   = 16'hFF00;

    localparam logic [7:0] FC_READ_FIRST  = 8'd1;
    localparam logic [7:0] FC_WRITE_COIL  = 8'd5;
    localparam logic [7:0] FC_WRITE_REG   = 8'd6;
    localparam logic [7:0] FC_WRITE_MULTI = 8'd16;

    localparam logic [7:0] CFG_REPORT_ID = 8'd0;
    localparam logic [7:0] CFG_REBOOT    = 8'd1;

    localparam logic [7:0]  REPORT_ID_RESET = 8'd17;
    localparam logic [7:0]  REBOOT_RESET    = 8'd0;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SLAVE  = 2'd1,
        ERR_LENGTH = 2'd2,
        ERR_CODE   = 2'd3
    } err_t;

    typedef enum logic {
        KIND_HEADER = 1'b0,
        KIND_DATA   = 1'b1
    } kind_t;

    // One queued transaction for the back end: plain bytes, then optional CRC.
    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] bytes;
        logic [2:0]                nbytes;
        logic                      init_crc;
        logic                      add_crc;
        err_t                      err;
    } cmd_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### rtl/core/mrf_req_if.sv
// Request channel of the Modbus RTU request framer.
// Valid/ready handshake with the header or data word payload.
interface mrf_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  slave_id;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] item_count;
    logic [15:0] data_word;

    modport source (output valid, func, slave_id, function_code, start_address,
                    item_count, data_word, input ready);
    modport sink   (input valid, func, slave_id, function_code, start_address,
                    item_count, data_word, output ready);
endinterface

### rtl/core/mrf_frame_if.sv
// Frame byte channel of the Modbus RTU request framer.
// Valid/ready handshake carrying one frame byte or an error result.
interface mrf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [1:0] error;

    modport source (output valid, frame_byte, last_byte, error, input ready);
    modport sink   (input valid, frame_byte, last_byte, error, output ready);
endinterface

### rtl/core/mrf_cfg_if.sv
// Configuration write channel of the Modbus RTU request framer.
// Valid/ready handshake carrying a register index and write data.
interface mrf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] reg_index;
    logic [7:0] data;

    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

### rtl/core/modbus_rtu_request_framer.sv
// Modbus RTU request framer: request items in, frame bytes with CRC-16/MODBUS out.
// Accepted items pass through the 2-entry queue into the back-end command register,
// which takes no new item until the current one is played out, and leave through the
// registered output stage one frame byte per cycle while the frame sink is ready.
// Reset clears the queue, word count and output stage; config registers return to 17 and 0.
module modbus_rtu_request_framer #(
    parameter int MAX_FRAME = mrf_pkg::MAX_FRAME_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    mrf_req_if.sink     req,
    mrf_cfg_if.sink     cfg,
    mrf_frame_if.source frame
);
    import mrf_pkg::*;

    logic push_valid, push_ready;
    cmd_t push_data;
    logic pop_valid, pop_ready;
    cmd_t pop_data;

    mrf_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mrf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .frame     (frame)
    );

endmodule

### rtl/core/mrf_front.sv
// Front end: accepts request items, classifies them and builds commands.
// Tracks the multiple-write word count. Depends on mrf_pkg and the channel interfaces.
module mrf_front #(
    parameter int MAX_FRAME = mrf_pkg::MAX_FRAME_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    mrf_req_if.sink        req,
    mrf_cfg_if.sink        cfg,
    output logic           push_valid,
    input  logic           push_ready,
    output mrf_pkg::cmd_t  push_data
);
    import mrf_pkg::*;

    localparam int LEN_W = 18;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);

    logic       awaiting_reg, awaiting_next;
    logic [7:0] words_left_reg, words_left_next;
    logic [7:0] report_id_reg;
    logic [7:0] reboot_reg;

    logic             accept;
    logic             produce;
    cmd_t             cmd;
    logic [15:0]      w2;
    logic [LEN_W-1:0] frame_len;
    logic             std_code;
    logic             multi_open;

    assign req.ready = push_ready;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            report_id_reg <= REPORT_ID_RESET;
            reboot_reg    <= REBOOT_RESET;
        end
        else if (cfg.valid) begin
            if (cfg.reg_index == CFG_REPORT_ID)
                report_id_reg <= cfg.data;
            else if (cfg.reg_index == CFG_REBOOT)
                reboot_reg <= cfg.data;
        end
    end

    always_comb begin
        std_code   = (req.function_code >= FC_READ_FIRST && req.function_code <= FC_WRITE_REG)
                     || req.function_code == FC_WRITE_MULTI;
        frame_len  = LEN_W'({req.item_count, 1'b0}) + LEN_W'(6);
        multi_open = req.function_code == FC_WRITE_MULTI && req.item_count != 16'd0;

        if (req.function_code == FC_WRITE_COIL)
            w2 = (req.data_word != 16'd0) ? COIL_ON : 16'd0;
        else if (req.function_code == FC_WRITE_REG)
            w2 = req.data_word;
        else
            w2 = req.item_count;

        cmd             = '0;
        cmd.err         = ERR_NONE;
        produce         = 1'b0;
        awaiting_next   = awaiting_reg;
        words_left_next = words_left_reg;

        if (kind_t'(req.func) == KIND_DATA) begin
            if (awaiting_reg) begin
                produce         = 1'b1;
                cmd.bytes[0]    = req.data_word[15:8];
                cmd.bytes[1]    = req.data_word[7:0];
                cmd.nbytes      = 3'd2;
                cmd.add_crc     = words_left_reg == 8'd1;
                words_left_next = words_left_reg - 8'd1;
                awaiting_next   = words_left_reg != 8'd1;
            end
        end
        else if (!awaiting_reg) begin
            produce = 1'b1;
            priority if (req.slave_id > MAX_SLAVE) begin
                cmd.err = ERR_SLAVE;
            end
            else if (std_code) begin
                if (multi_open && frame_len >= MAX_LEN) begin
                    cmd.err = ERR_LENGTH;
                end
                else begin
                    cmd.bytes[0] = req.slave_id;
                    cmd.bytes[1] = req.function_code;
                    cmd.bytes[2] = req.start_address[15:8];
                    cmd.bytes[3] = req.start_address[7:0];
                    cmd.bytes[4] = w2[15:8];
                    cmd.bytes[5] = w2[7:0];
                    cmd.bytes[6] = {req.item_count[6:0], 1'b0};
                    cmd.nbytes   = (req.function_code == FC_WRITE_MULTI) ? 3'd7 : 3'd6;
                    cmd.init_crc = 1'b1;
                    cmd.add_crc  = !multi_open;
                    if (multi_open) begin
                        awaiting_next   = 1'b1;
                        words_left_next = req.item_count[7:0];
                    end
                end
            end
            else if (req.function_code == report_id_reg
                     || (reboot_reg != 8'd0 && req.function_code == reboot_reg)) begin
                cmd.bytes[0] = req.slave_id;
                cmd.bytes[1] = req.function_code;
                cmd.nbytes   = 3'd2;
                cmd.init_crc = 1'b1;
                cmd.add_crc  = 1'b1;
            end
            else begin
                cmd.err = ERR_CODE;
            end
        end
    end

    assign push_valid = accept && produce;
    assign push_data  = cmd;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            awaiting_reg   <= 1'b0;
            words_left_reg <= 8'd0;
        end
        else if (accept) begin
            awaiting_reg   <= awaiting_next;
            words_left_reg <= words_left_next;
        end
    end

    a_words_pending: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> words_left_reg != 8'd0)
        else $error("awaiting data words with zero count");

    a_err_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_data.err != ERR_NONE) |=> !awaiting_reg)
        else $error("error result opened a multiple write");

    a_ok_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_data.err == ERR_NONE) |-> push_data.nbytes != 3'd0)
        else $error("frame command without bytes");

endmodule

### rtl/core/mrf_queue.sv
// Short command queue between front and back end.
// Register-based circular buffer; depends on mrf_pkg for the command type.
module mrf_queue #(
    parameter int DEPTH = mrf_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  mrf_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output mrf_pkg::cmd_t pop_data
);
    import mrf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk) begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### rtl/core/mrf_back.sv
// Back end: plays out queued commands one byte per cycle while the frame sink is ready, running CRC-16/MODBUS.
// Registered output stage; depends on mrf_pkg and the frame channel interface.
module mrf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  mrf_pkg::cmd_t pop_data,
    mrf_frame_if.source   frame
);
    import mrf_pkg::*;

    cmd_t        cmd_reg;
    logic        busy_reg, busy_next;
    logic [3:0]  idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;
    err_t        out_err_reg, out_err_next;

    logic        step;
    logic        done;
    logic        load;
    logic [3:0]  nbytes_w;

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.last_byte  = out_last_reg;
    assign frame.error      = out_err_reg;

    assign pop_ready = !busy_reg;
    assign load      = pop_valid && !busy_reg;
    assign step      = busy_reg && (!out_valid_reg || frame.ready);
    assign nbytes_w  = {1'b0, cmd_reg.nbytes};

    always_comb begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && !frame.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        done           = 1'b0;

        if (load) begin
            busy_next = 1'b1;
            idx_next  = 4'd0;
            if (pop_data.init_crc)
                crc_next = CRC_INIT;
        end
        else if (step) begin
            out_valid_next = 1'b1;
            out_err_next   = ERR_NONE;
            out_last_next  = 1'b0;
            priority if (cmd_reg.err != ERR_NONE) begin
                out_byte_next = 8'd0;
                out_last_next = 1'b1;
                out_err_next  = cmd_reg.err;
                crc_next      = CRC_INIT;
                done          = 1'b1;
            end
            else if (idx_reg < nbytes_w) begin
                out_byte_next = cmd_reg.bytes[idx_reg[2:0]];
                crc_next      = crc_step(crc_reg, cmd_reg.bytes[idx_reg[2:0]]);
                done          = (idx_reg == nbytes_w - 4'd1) && !cmd_reg.add_crc;
            end
            else if (idx_reg == nbytes_w) begin
                out_byte_next = crc_reg[7:0];
            end
            else begin
                // high CRC byte closes the frame
                out_byte_next = crc_reg[15:8];
                out_last_next = 1'b1;
                crc_next      = CRC_INIT;
                done          = 1'b1;
            end
            idx_next  = idx_reg + 4'd1;
            busy_next = !done;
        end
    end

    always_ff @(posedge clk) begin
        if (load)
            cmd_reg <= pop_data;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            idx_reg       <= 4'd0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg != ERR_NONE) |-> (out_last_reg && out_byte_reg == 8'd0))
        else $error("error result not a single zero byte");

    a_crc_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (step && out_last_next) |=> crc_reg == CRC_INIT)
        else $error("CRC not reinitialized after frame end");

    a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> idx_reg == 4'd0)
        else $error("command started mid-sequence");

endmodule

### bench/modbus_rtu_request_framer_test.sv
// Self-checking bench for the Modbus RTU request framer: random and directed requests
// in, frame bytes checked against a CRC-16/MODBUS frame predictor.
// Depends on mrf_pkg and the request, config and frame channel interfaces.
`timescale 1ns / 1ps

module modbus_rtu_request_framer_test;
    import mrf_pkg::*;

    localparam int FRAME_LIMIT   = MAX_FRAME_DEFAULT;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;

    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT    = 8'd4;
    localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
    localparam logic [7:0] FC_UNUSED_LOW    = 8'd0;
    localparam logic [7:0] FC_UNUSED_HIGH   = 8'd255;

    typedef struct {
        kind_t       func;
        logic [7:0]  slave_id;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] item_count;
        logic [15:0] data_word;
    } request_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        err_t       error;
    } frame_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    mrf_req_if   req_ch ();
    mrf_cfg_if   cfg_ch ();
    mrf_frame_if frame_ch ();

    modbus_rtu_request_framer #(
        .MAX_FRAME(FRAME_LIMIT)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .cfg  (cfg_ch),
        .frame(frame_ch)
    );

    always #4 clk = ~clk;

    request_t    pending_items[$];
    frame_beat_t expected_bytes[$];
    request_t    on_bus;
    int          fault_count = 0;
    int          stall_pct   = 25;
    int          gap_left    = 0;
    int          stall_left  = 0;

    // Frame predictor state
    logic [15:0] crc_run   = CRC_INIT;
    logic [7:0]  words_due = 8'd0;
    logic        in_multi  = 1'b0;
    logic [7:0]  rid_code  = REPORT_ID_RESET;
    logic [7:0]  rbt_code  = REBOOT_RESET;

    function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] acc,
                                                      input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8)
            r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
        return r;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic is_last);
        frame_beat_t beat;
        crc_run = crc16_modbus_byte(crc_run, b);
        beat.frame_byte = b;
        beat.last_byte  = is_last;
        beat.error      = ERR_NONE;
        expected_bytes.push_back(beat);
    endfunction

    function automatic void push_crc();
        logic [15:0] c;
        c = crc_run;
        push_byte(c[7:0], 1'b0);
        push_byte(c[15:8], 1'b1);
        crc_run = CRC_INIT;
    endfunction

    function automatic void push_error(input err_t e);
        frame_beat_t beat;
        beat.frame_byte = 8'h00;
        beat.last_byte  = 1'b1;
        beat.error      = e;
        expected_bytes.push_back(beat);
        crc_run = CRC_INIT;
    endfunction

    function automatic void frame_predict(input request_t it);
        logic [7:0]  fc;
        logic [15:0] word2;
        fc = it.function_code;
        if (it.func == KIND_DATA) begin
            if (!in_multi)
                return;
            push_byte(it.data_word[15:8], 1'b0);
            push_byte(it.data_word[7:0], 1'b0);
            words_due = words_due - 8'd1;
            if (words_due == 8'd0) begin
                in_multi = 1'b0;
                push_crc();
            end
            return;
        end
        // Headers are dropped while a multiple write is still collecting words
        if (in_multi)
            return;
        if (it.slave_id > MAX_SLAVE) begin
            push_error(ERR_SLAVE);
            return;
        end
        crc_run = CRC_INIT;
        if ((fc >= FC_READ_FIRST && fc <= FC_WRITE_REG) || fc == FC_WRITE_MULTI) begin
            if (fc == FC_WRITE_MULTI && it.item_count != 16'd0
                    && 6 + 2 * int'(it.item_count) >= FRAME_LIMIT) begin
                push_error(ERR_LENGTH);
                return;
            end
            if (fc == FC_WRITE_COIL)
                word2 = (it.data_word != 16'd0) ? COIL_ON : 16'h0000;
            else if (fc == FC_WRITE_REG)
                word2 = it.data_word;
            else
                word2 = it.item_count;
            push_byte(it.slave_id, 1'b0);
            push_byte(fc, 1'b0);
            push_byte(it.start_address[15:8], 1'b0);
            push_byte(it.start_address[7:0], 1'b0);
            push_byte(word2[15:8], 1'b0);
            push_byte(word2[7:0], 1'b0);
            if (fc == FC_WRITE_MULTI) begin
                push_byte({it.item_count[6:0], 1'b0}, 1'b0);
                if (it.item_count != 16'd0) begin
                    words_due = it.item_count[7:0];
                    in_multi  = 1'b1;
                    return;
                end
            end
            push_crc();
        end
        else if (fc == rid_code || (rbt_code != 8'd0 && fc == rbt_code)) begin
            push_byte(it.slave_id, 1'b0);
            push_byte(fc, 1'b0);
            push_crc();
        end
        else begin
            push_error(ERR_CODE);
        end
    endfunction

    function automatic request_t header(input logic [7:0] id, input logic [7:0] fc,
                                        input logic [15:0] addr, input logic [15:0] cnt,
                                        input logic [15:0] dw);
        request_t it;
        it.func          = KIND_HEADER;
        it.slave_id      = id;
        it.function_code = fc;
        it.start_address = addr;
        it.item_count    = cnt;
        it.data_word     = dw;
        return it;
    endfunction

    function automatic request_t data_item(input logic [15:0] dw);
        request_t it;
        it = header(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), dw);
        it.func = KIND_DATA;
        return it;
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid         <= 1'b0;
            req_ch.func          <= KIND_HEADER;
            req_ch.slave_id      <= 8'h00;
            req_ch.function_code <= 8'h00;
            req_ch.start_address <= 16'h0000;
            req_ch.item_count    <= 16'h0000;
            req_ch.data_word     <= 16'h0000;
            gap_left = 0;
        end
        else begin
            if (req_ch.valid && req_ch.ready)
                frame_predict(on_bus);
            if (!req_ch.valid || req_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0) begin
                    on_bus = pending_items.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.func          <= on_bus.func;
                    req_ch.slave_id      <= on_bus.slave_id;
                    req_ch.function_code <= on_bus.function_code;
                    req_ch.start_address <= on_bus.start_address;
                    req_ch.item_count    <= on_bus.item_count;
                    req_ch.data_word     <= on_bus.data_word;
                    if ($urandom_range(0, 99) < stall_pct)
                        gap_left = $urandom_range(1, 3);
                end
                else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Frame monitor
    always @(posedge clk or negedge rst_n) begin
        frame_beat_t want;
        if (!rst_n) begin
            frame_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else begin
            if (frame_ch.valid && frame_ch.ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected frame transaction: frame_byte %h last_byte %b error %0d",
                           frame_ch.frame_byte, frame_ch.last_byte, frame_ch.error);
                    fault_count++;
                end
                else begin
                    want = expected_bytes.pop_front();
                    if (frame_ch.frame_byte !== want.frame_byte) begin
                        $error("frame_byte: expected %h, actual %h",
                               want.frame_byte, frame_ch.frame_byte);
                        fault_count++;
                    end
                    if (frame_ch.last_byte !== want.last_byte) begin
                        $error("last_byte: expected %b, actual %b",
                               want.last_byte, frame_ch.last_byte);
                        fault_count++;
                    end
                    if (frame_ch.error !== want.error) begin
                        $error("error: expected %0d, actual %0d", want.error, frame_ch.error);
                        fault_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                frame_ch.ready <= 1'b0;
            end
            else begin
                frame_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = $urandom_range(1, 3);
            end
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.data      <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_REPORT_ID)
            rid_code = val;
        else if (idx == CFG_REBOOT)
            rbt_code = val;
        @(negedge clk);
    endtask

    // Wait for every request to be taken and every frame byte to arrive, then settle.
    task automatic wait_drained();
        int spin;
        spin = 0;
        while ((pending_items.size() != 0 || req_ch.valid || expected_bytes.size() != 0)
                && spin < DRAIN_LIMIT) begin
            @(negedge clk);
            spin++;
        end
        if (spin >= DRAIN_LIMIT) begin
            $error("%0d expected frame bytes never arrived", expected_bytes.size());
            fault_count++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly well-formed requests with random content, plus some noise.
    task automatic gen_traffic(input int goal);
        int          count;
        int          pick;
        int          sel;
        logic [15:0] cnt;
        logic [7:0]  fc;
        count = 0;
        while (count < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                fc = 8'($urandom_range(FC_READ_COILS, FC_READ_INPUT));
                pending_items.push_back(header(8'($urandom_range(0, 247)), fc,
                                               16'($urandom), 16'($urandom), 16'($urandom)));
                count++;
            end
            else if (pick < 45) begin
                pending_items.push_back(header(8'($urandom_range(0, 247)), FC_WRITE_COIL,
                                               16'($urandom), 16'($urandom),
                                               $urandom_range(0, 1) ? 16'($urandom)
                                                                    : 16'h0000));
                count++;
            end
            else if (pick < 55) begin
                pending_items.push_back(header(8'($urandom_range(0, 247)), FC_WRITE_REG,
                                               16'($urandom), 16'($urandom), 16'($urandom)));
                count++;
            end
            else if (pick < 75) begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    cnt = 16'd0;
                else if (sel == 1)
                    cnt = 16'((FRAME_LIMIT - 7) / 2);
                else if (sel == 2)
                    cnt = 16'($urandom_range((FRAME_LIMIT - 6) / 2, 65535));
                else
                    cnt = 16'($urandom_range(1, 6));
                pending_items.push_back(header(8'($urandom_range(0, 247)), FC_WRITE_MULTI,
                                               16'($urandom), cnt, 16'($urandom)));
                count++;
                if (cnt != 16'd0 && 6 + 2 * int'(cnt) < FRAME_LIMIT) begin
                    for (int w = 0; w < int'(cnt); w++) begin
                        // Drop in a stray header now and then; it must be ignored
                        if ($urandom_range(0, 7) == 0)
                            pending_items.push_back(header(8'($urandom), 8'($urandom),
                                                           16'($urandom), 16'($urandom),
                                                           16'($urandom)));
                        pending_items.push_back(data_item(16'($urandom)));
                        count++;
                    end
                end
            end
            else if (pick < 85) begin
                fc = ($urandom_range(0, 1) && rbt_code != 8'd0) ? rbt_code : rid_code;
                pending_items.push_back(header(8'($urandom_range(0, 247)), fc,
                                               16'($urandom), 16'($urandom), 16'($urandom)));
                count++;
            end
            else if (pick < 95) begin
                if ($urandom_range(0, 1))
                    pending_items.push_back(header(8'($urandom_range(248, 255)), 8'($urandom),
                                                   16'($urandom), 16'($urandom),
                                                   16'($urandom)));
                else
                    pending_items.push_back(header(8'($urandom), 8'($urandom),
                                                   16'($urandom), 16'($urandom),
                                                   16'($urandom)));
                count++;
            end
            else begin
                pending_items.push_back(data_item(16'($urandom)));
            end
        end
    endtask

    initial begin
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.func          = KIND_HEADER;
        req_ch.slave_id      = 8'h00;
        req_ch.function_code = 8'h00;
        req_ch.start_address = 16'h0000;
        req_ch.item_count    = 16'h0000;
        req_ch.data_word     = 16'h0000;
        cfg_ch.valid         = 1'b0;
        cfg_ch.reg_index     = CFG_REPORT_ID;
        cfg_ch.data          = 8'h00;
        frame_ch.ready       = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed cases under the reset configuration
        pending_items.push_back(header(8'd0, FC_READ_COILS, 16'h0000, 16'h0000, 16'h0000));
        pending_items.push_back(header(MAX_SLAVE, FC_READ_DISCRETE, 16'hFFFF, 16'hFFFF,
                                       16'hFFFF));
        pending_items.push_back(header(8'd17, FC_READ_HOLDING, 16'h1234, 16'h000A, 16'h0000));
        pending_items.push_back(header(8'd1, FC_READ_INPUT, 16'h8001, 16'h0100, 16'h5AA5));
        pending_items.push_back(header(8'd5, FC_WRITE_COIL, 16'h00AC, 16'h0000, 16'h0001));
        pending_items.push_back(header(8'd5, FC_WRITE_COIL, 16'h00AC, 16'hFFFF, 16'h0000));
        pending_items.push_back(header(8'd9, FC_WRITE_REG, 16'h0001, 16'h0000, 16'hFFFF));
        pending_items.push_back(header(8'd248, FC_READ_HOLDING, 16'h0000, 16'h0001, 16'h0000));
        pending_items.push_back(header(8'd255, FC_WRITE_MULTI, 16'h0000, 16'h0002, 16'h0000));
        pending_items.push_back(header(8'd3, FC_UNUSED_LOW, 16'h0000, 16'h0000, 16'h0000));
        pending_items.push_back(header(8'd3, FC_WRITE_COILS, 16'h0013, 16'h000A, 16'h0000));
        pending_items.push_back(header(8'd3, FC_UNUSED_HIGH, 16'h0000, 16'h0000, 16'h0000));
        pending_items.push_back(header(8'd4, REPORT_ID_RESET, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(data_item(16'hBEEF));
        pending_items.push_back(header(8'd1, FC_WRITE_MULTI, 16'h0010, 16'h0000, 16'h0000));
        pending_items.push_back(header(8'd1, FC_WRITE_MULTI, 16'h0010,
                                       16'((FRAME_LIMIT - 6) / 2), 16'h0000));
        pending_items.push_back(header(8'd1, FC_WRITE_MULTI, 16'h0010, 16'hFFFF, 16'h0000));
        pending_items.push_back(header(8'd2, FC_WRITE_MULTI, 16'h0100, 16'h0002, 16'h0000));
        pending_items.push_back(data_item(16'hA55A));
        pending_items.push_back(header(8'd2, FC_READ_COILS, 16'h0000, 16'h0001, 16'h0000));
        pending_items.push_back(data_item(16'hFFFF));
        gen_traffic(30);
        wait_drained();

        stall_pct = 10;
        write_reg(CFG_REPORT_ID, 8'h00);
        write_reg(CFG_REBOOT, 8'hFF);
        pending_items.push_back(header(8'd7, FC_UNUSED_LOW, 16'h0000, 16'h0000, 16'h0000));
        pending_items.push_back(header(8'd7, FC_UNUSED_HIGH, 16'h0000, 16'h0000, 16'h0000));
        pending_items.push_back(header(8'd7, REPORT_ID_RESET, 16'h0000, 16'h0000, 16'h0000));
        gen_traffic(30);
        wait_drained();

        stall_pct = 40;
        write_reg(CFG_REPORT_ID, 8'hFF);
        pending_items.push_back(header(8'd8, FC_UNUSED_HIGH, 16'h0000, 16'h0000, 16'h0000));
        wait_drained();
        // Standard codes win over both registers
        write_reg(CFG_REPORT_ID, FC_READ_HOLDING);
        write_reg(CFG_REBOOT, FC_WRITE_MULTI);
        pending_items.push_back(header(8'd8, FC_READ_HOLDING, 16'h0102, 16'h0304, 16'h0000));
        pending_items.push_back(header(8'd8, FC_WRITE_MULTI, 16'h0102, 16'h0001, 16'h0000));
        pending_items.push_back(data_item(16'h1234));
        gen_traffic(25);
        wait_drained();

        // No idling in the closing stretch
        stall_pct = 0;
        write_reg(CFG_REPORT_ID, 8'($urandom));
        write_reg(CFG_REBOOT, 8'($urandom));
        gen_traffic(35);
        wait_drained();

        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
rtl/core/mrf_pkg.sv
rtl/core/mrf_req_if.sv
rtl/core/mrf_frame_if.sv
rtl/core/mrf_cfg_if.sv
rtl/core/mrf_front.sv
rtl/core/mrf_queue.sv
rtl/core/mrf_back.sv
rtl/core/modbus_rtu_request_framer.sv
bench/modbus_rtu_request_framer_test.sv
